>>> hw/rtl/rhc_pkg.sv
// Shared types and default constants for the RGB to HSV converter.
package rhc_pkg;

  localparam int CHANNEL_BITS_DEF      = 8;
  localparam int HUE_FRACTION_BITS_DEF = 6;
  localparam int HUE_INT_BITS          = 9;
  localparam int SAT_BITS              = 16;
  localparam int HUE_SPAN_BITS         = 6;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

endpackage

>>> hw/rtl/rgb_to_hsv_converter.sv
// Pipelined RGB to HSV converter with restoring dividers for hue and saturation.
//
//  channel  dir  group                      fields (lowest bit first)
//  pixel    in   s_tvalid/s_tready/s_tdata  red, green, blue
//  hsv      out  m_tvalid/m_tready/m_tdata  hue, saturation, value
//
// One pixel enters per clock while the output side is not stalled; NSTEP is the
// longer of the two divisions (16 saturation bits, or 6 + HUE_FRACTION_BITS hue
// bits), one quotient bit per stage.
// Reset clears the stage valid bits only; the data registers are not reset.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and new pixels are taken while a finished result waits.
module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS      = rhc_pkg::CHANNEL_BITS_DEF,
  parameter int HUE_FRACTION_BITS = rhc_pkg::HUE_FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // red, green, blue, zero padded to whole bytes
  input  logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hue, saturation, value, zero padded to whole bytes
  output logic [((rhc_pkg::HUE_INT_BITS + HUE_FRACTION_BITS + rhc_pkg::SAT_BITS
                  + CHANNEL_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int CB    = CHANNEL_BITS;
  localparam int HF    = HUE_FRACTION_BITS;
  localparam int HW    = rhc_pkg::HUE_INT_BITS + HF;
  localparam int SB    = rhc_pkg::SAT_BITS;
  localparam int QWH   = rhc_pkg::HUE_SPAN_BITS + HF;
  localparam int NWH   = CB + QWH;
  localparam int NWS   = CB + SB;
  localparam int NSTEP = (QWH > SB) ? QWH : SB;
  localparam int NS    = NSTEP + 4;
  localparam int OUT_W = ((HW + SB + CB + 7) / 8) * 8;

  localparam logic [QWH-1:0] HUE_SCALE = QWH'(60 * (1 << HF));
  localparam logic [HW-1:0]  HUE_120   = HW'(120 * (1 << HF));
  localparam logic [HW-1:0]  HUE_240   = HW'(240 * (1 << HF));
  localparam logic [HW-1:0]  HUE_360   = HW'(360 * (1 << HF));

  // Stage valid bits and per-stage advance enables.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NS-1];

  // Stage 0: input register.
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      red   <= s_tdata[CB-1:0];
      green <= s_tdata[2*CB-1:CB];
      blue  <= s_tdata[3*CB-1:2*CB];
    end
  end

  // Stage 1: largest and smallest channel, sector and signed difference.
  logic [CB-1:0]        hi_c;
  logic [CB-1:0]        lo_c;
  rhc_pkg::sector_t     sector_c;
  logic [CB:0]          diff_c;
  logic [CB:0]          diff_abs_c;
  logic [CB-1:0]        s1_hi;
  logic [CB-1:0]        s1_delta;
  logic [CB-1:0]        s1_absd;
  logic                 s1_neg;
  rhc_pkg::sector_t     s1_sector;

  always_comb begin
    hi_c = red;
    lo_c = red;
    if (green > hi_c) hi_c = green;
    if (blue > hi_c) hi_c = blue;
    if (green < lo_c) lo_c = green;
    if (blue < lo_c) lo_c = blue;
    if (hi_c == red) begin
      sector_c = rhc_pkg::SECTOR_RED;
      diff_c   = {1'b0, green} - {1'b0, blue};
    end else if (hi_c == green) begin
      sector_c = rhc_pkg::SECTOR_GREEN;
      diff_c   = {1'b0, blue} - {1'b0, red};
    end else begin
      sector_c = rhc_pkg::SECTOR_BLUE;
      diff_c   = {1'b0, red} - {1'b0, green};
    end
    diff_abs_c = diff_c[CB] ? (~diff_c + (CB+1)'(1)) : diff_c;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_hi     <= hi_c;
      s1_delta  <= hi_c - lo_c;
      s1_absd   <= diff_abs_c[CB-1:0];
      s1_neg    <= diff_c[CB];
      s1_sector <= sector_c;
    end
  end

  // Stage 2 onward: divider pipeline. Index 0 holds the dividends, index k
  // holds the state after k quotient bits.
  logic [CB-1:0]    d_hi     [0:NSTEP];
  logic [CB-1:0]    d_delta  [0:NSTEP];
  logic             d_neg    [0:NSTEP];
  rhc_pkg::sector_t d_sector [0:NSTEP];
  logic [CB-1:0]    h_rem    [0:NSTEP];
  logic [QWH-1:0]   h_low    [0:NSTEP];
  logic [CB-1:0]    s_rem    [0:NSTEP];
  logic [SB-1:0]    s_low    [0:NSTEP];

  logic [NWH-1:0] h_dvd_c;
  logic [NWS-1:0] s_dvd_c;

  always_comb begin
    h_dvd_c = NWH'(s1_absd) * NWH'(HUE_SCALE);
    s_dvd_c = {s1_delta, SB'(0)} - NWS'(s1_delta);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d_hi[0]     <= s1_hi;
      d_delta[0]  <= s1_delta;
      d_neg[0]    <= s1_neg;
      d_sector[0] <= s1_sector;
      // The quotient fits its bit count, so the top bits are already below the divisor.
      h_rem[0]    <= h_dvd_c[NWH-1:QWH];
      h_low[0]    <= h_dvd_c[QWH-1:0];
      s_rem[0]    <= s_dvd_c[NWS-1:SB];
      s_low[0]    <= s_dvd_c[SB-1:0];
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        d_hi[k]     <= d_hi[k-1];
        d_delta[k]  <= d_delta[k-1];
        d_neg[k]    <= d_neg[k-1];
        d_sector[k] <= d_sector[k-1];
      end
    end

    if (k <= QWH) begin : g_hue
      logic [CB:0] t;
      logic        ge;
      always_comb begin
        t  = {h_rem[k-1], h_low[k-1][QWH-1]};
        ge = t >= {1'b0, d_delta[k-1]};
      end
      always_ff @(posedge clk) begin
        if (en[2+k]) begin
          h_rem[k] <= ge ? CB'(t - {1'b0, d_delta[k-1]}) : t[CB-1:0];
          h_low[k] <= {h_low[k-1][QWH-2:0], ge};
        end
      end
    end else begin : g_hue_pass
      always_ff @(posedge clk) begin
        if (en[2+k]) begin
          h_rem[k] <= h_rem[k-1];
          h_low[k] <= h_low[k-1];
        end
      end
    end

    if (k <= SB) begin : g_sat
      logic [CB:0] t;
      logic        ge;
      always_comb begin
        t  = {s_rem[k-1], s_low[k-1][SB-1]};
        ge = t >= {1'b0, d_hi[k-1]};
      end
      always_ff @(posedge clk) begin
        if (en[2+k]) begin
          s_rem[k] <= ge ? CB'(t - {1'b0, d_hi[k-1]}) : t[CB-1:0];
          s_low[k] <= {s_low[k-1][SB-2:0], ge};
        end
      end
    end else begin : g_sat_pass
      always_ff @(posedge clk) begin
        if (en[2+k]) begin
          s_rem[k] <= s_rem[k-1];
          s_low[k] <= s_low[k-1];
        end
      end
    end
  end

  // Final stage: place the hue quotient in its sector and wrap negatives.
  logic [HW-1:0] q_c;
  logic [HW-1:0] hue_c;
  logic [HW-1:0] out_hue;
  logic [SB-1:0] out_sat;
  logic [CB-1:0] out_value;

  always_comb begin
    q_c = HW'(h_low[NSTEP]);
    case (d_sector[NSTEP])
      rhc_pkg::SECTOR_RED: begin
        // A negative hue in the red sector wraps to the top of the circle.
        hue_c = (d_neg[NSTEP] && (q_c != '0)) ? (HUE_360 - q_c) : q_c;
      end
      rhc_pkg::SECTOR_GREEN: begin
        hue_c = d_neg[NSTEP] ? (HUE_120 - q_c) : (HUE_120 + q_c);
      end
      rhc_pkg::SECTOR_BLUE: begin
        hue_c = d_neg[NSTEP] ? (HUE_240 - q_c) : (HUE_240 + q_c);
      end
      default: begin
        hue_c = '0;
      end
    endcase
    if (d_delta[NSTEP] == '0) begin
      hue_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_hue   <= hue_c;
      out_sat   <= (d_delta[NSTEP] == '0) ? '0 : s_low[NSTEP];
      out_value <= d_hi[NSTEP];
    end
  end

  assign m_tdata = OUT_W'({out_value, out_sat, out_hue});

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_hue < HUE_360))
    else $error("hue at or above a full circle");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_value == '0)) |-> ((out_hue == '0) && (out_sat == '0)))
    else $error("black pixel with nonzero hue or saturation");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the output side can move");

  a_full_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_sat == '1)) |-> (out_value != '0))
    else $error("full saturation on a black pixel");
`endif

endmodule

>>> tb/rgb_to_hsv_converter_tb.sv
// Self-checking testbench for the RGB to HSV converter with a pixel stream and a scoreboard.
module rgb_to_hsv_converter_tb;

  localparam int CH_W      = rhc_pkg::CHANNEL_BITS_DEF;
  localparam int HFRAC     = rhc_pkg::HUE_FRACTION_BITS_DEF;
  localparam int HUE_W     = rhc_pkg::HUE_INT_BITS + HFRAC;
  localparam int SAT_W     = rhc_pkg::SAT_BITS;
  localparam int PIX_W     = ((3 * CH_W + 7) / 8) * 8;
  localparam int HSV_W     = ((HUE_W + SAT_W + CH_W + 7) / 8) * 8;
  localparam int HUE_UNIT  = 1 << HFRAC;
  localparam int HUE_SCALE = 60 * HUE_UNIT;
  localparam int HUE_FULL  = 360 * HUE_UNIT;
  localparam int CH_MAX    = (1 << CH_W) - 1;
  localparam int SAT_FULL  = (1 << SAT_W) - 1;
  localparam int RANDOM_PIXELS = 1530;
  localparam int HOLD_CYCLES   = 150;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [CH_W-1:0]  value;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t expected_hsv_q[$];
    int   mismatches;
    int   checked;
    int   greys;
    int   ties;

    function new();
      mismatches = 0;
      checked    = 0;
      greys      = 0;
      ties       = 0;
    endfunction

    function hsv_t predict_hsv(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      int ri, gi, bi, hi, lo, delta, diff, base, hue, sat;
      rhc_pkg::sector_t sector;
      hsv_t res;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      hi = ri;
      lo = ri;
      if (gi > hi) hi = gi;
      if (bi > hi) hi = bi;
      if (gi < lo) lo = gi;
      if (bi < lo) lo = bi;
      delta = hi - lo;
      hue = 0;
      sat = 0;
      if (delta > 0) begin
        // Ties on the largest channel resolve red first, then green.
        if (hi == ri) sector = rhc_pkg::SECTOR_RED;
        else if (hi == gi) sector = rhc_pkg::SECTOR_GREEN;
        else sector = rhc_pkg::SECTOR_BLUE;
        case (sector)
          rhc_pkg::SECTOR_RED: begin
            diff = gi - bi;
            base = 0;
          end
          rhc_pkg::SECTOR_GREEN: begin
            diff = bi - ri;
            base = 120;
          end
          default: begin
            diff = ri - gi;
            base = 240;
          end
        endcase
        // Integer division truncates toward zero, as the hue needs.
        hue = base * HUE_UNIT + (HUE_SCALE * diff) / delta;
        if (hue < 0) hue += HUE_FULL;
        sat = (delta * SAT_FULL) / hi;
      end
      res.hue   = hue[HUE_W-1:0];
      res.sat   = sat[SAT_W-1:0];
      res.value = hi[CH_W-1:0];
      return res;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      logic [CH_W-1:0] r, g, b;
      r = px[CH_W-1:0];
      g = px[2*CH_W-1:CH_W];
      b = px[3*CH_W-1:2*CH_W];
      if (r == g && g == b) greys++;
      else if ((r == g && r >= b) || (r == b && r >= g) || (g == b && g >= r)) ties++;
      expected_hsv_q = {expected_hsv_q, predict_hsv(r, g, b)};
    endfunction

    function void check_hsv(logic [HSV_W-1:0] word);
      hsv_t exp_hsv;
      hsv_t got;
      got.hue   = word[HUE_W-1:0];
      got.sat   = word[HUE_W+SAT_W-1:HUE_W];
      got.value = word[HUE_W+SAT_W+CH_W-1:HUE_W+SAT_W];
      if (expected_hsv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result hue=%0d sat=%0d value=%0d",
                   got.hue, got.sat, got.value);
        return;
      end
      exp_hsv = expected_hsv_q.pop_front();
      checked++;
      if (got.hue !== exp_hsv.hue || got.sat !== exp_hsv.sat ||
          got.value !== exp_hsv.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d expected hue=%0d sat=%0d value=%0d,",
                    " got hue=%0d sat=%0d value=%0d"},
                   checked, exp_hsv.hue, exp_hsv.sat, exp_hsv.value,
                   got.hue, got.sat, got.value);
      end
    endfunction

    function int pending();
      return expected_hsv_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // red, green, blue
  logic [PIX_W-1:0] s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // hue, saturation, value
  logic [HSV_W-1:0] m_tdata;

  hsv_scoreboard sb = new();
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  rgb_to_hsv_converter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_hsv(m_tdata);
  end

  // The run is cut short when no request moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls per result, with one long hold-off on request.
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input bit no_gap);
    int gap;
    gap = (quiet || no_gap) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= PIX_W'({b, g, r});
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(PIX_W'({b, g, r}));
  endtask

  function automatic logic [CH_W-1:0] edge_level();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CH_W'(1);
      2: return CH_W'(CH_MAX - 1);
      3: return CH_W'(CH_MAX);
      default: return CH_W'($urandom_range(0, CH_MAX));
    endcase
  endfunction

  task automatic send_random_pixel(input bit no_gap);
    logic [CH_W-1:0] r, g, b, top, other;
    int kind;
    kind = $urandom_range(0, 99);
    r = CH_W'($urandom_range(0, CH_MAX));
    g = CH_W'($urandom_range(0, CH_MAX));
    b = CH_W'($urandom_range(0, CH_MAX));
    if (kind < 10) begin
      g = r;
      b = r;
    end else if (kind < 25) begin
      // Two channels share the maximum and the third lies at or below it.
      top   = CH_W'($urandom_range(1, CH_MAX));
      other = CH_W'($urandom_range(0, top));
      case ($urandom_range(0, 2))
        0: begin r = top; g = top; b = other; end
        1: begin r = top; b = top; g = other; end
        default: begin g = top; b = top; r = other; end
      endcase
    end else if (kind < 40) begin
      r = edge_level();
      g = edge_level();
      b = edge_level();
    end else if (kind < 48) begin
      r = CH_W'($urandom_range(0, 3));
      g = CH_W'($urandom_range(0, 3));
      b = CH_W'($urandom_range(0, 3));
    end
    send_pixel(r, g, b, no_gap);
  endtask

  initial begin
    logic [3*CH_W-1:0] directed[$];
    logic [3*CH_W-1:0] px;
    int i;
    // Each entry is {blue, green, red}.
    directed = '{
      {8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
      {8'd1,   8'd1,   8'd1},   {8'd0,   8'd0,   8'd255}, {8'd0,   8'd255, 8'd0},
      {8'd255, 8'd0,   8'd0},   {8'd0,   8'd255, 8'd255}, {8'd255, 8'd0,   8'd255},
      {8'd255, 8'd255, 8'd0},   {8'd1,   8'd0,   8'd255}, {8'd0,   8'd1,   8'd255},
      {8'd0,   8'd0,   8'd1},   {8'd254, 8'd254, 8'd255}, {8'd0,   8'd1,   8'd0},
      {8'd1,   8'd0,   8'd0},   {8'd50,  8'd100, 8'd200}, {8'd100, 8'd200, 8'd50},
      {8'd200, 8'd50,  8'd100}, {8'd30,  8'd20,  8'd10},  {8'd0,   8'd128, 8'd255},
      {8'd255, 8'd255, 8'd128}, {8'd255, 8'd0,   8'd1},   {8'd1,   8'd255, 8'd0}
    };
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed[k]) begin
      px = directed[k];
      send_pixel(px[CH_W-1:0], px[2*CH_W-1:CH_W], px[3*CH_W-1:2*CH_W], 1'b0);
    end

    for (i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == 400) hold_req = 1'b1;
      if (i == 800) begin
        // Let the pipeline empty completely before the next request.
        @(negedge clk) s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random_pixel(i >= 400 && i < 460);
    end
    @(negedge clk) s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    sb.mismatches += sb.pending();
    $display("Summary: %0d pixels checked, %0d grey and %0d with tied maxima, random stalls on",
             sb.checked, sb.greys, sb.ties);
    $display("both sides, one output hold-off of %0d cycles and one full drain.", HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", sb.mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rhc_pkg.sv
hw/rtl/rgb_to_hsv_converter.sv
tb/rgb_to_hsv_converter_tb.sv
